>>> rtl/pwmt_pkg.sv
// Shared types and register codes for the PWM timer.
`timescale 1ns / 1ps
`default_nettype none

package pwmt_pkg;

  // Bus command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register map
  localparam logic [3:0] REG_CTRL    = 4'd0;
  localparam logic [3:0] REG_STATUS  = 4'd1;
  localparam logic [3:0] REG_EVENT   = 4'd2;
  localparam logic [3:0] REG_IRQ_EN  = 4'd3;
  localparam logic [3:0] REG_COUNT   = 4'd4;
  localparam logic [3:0] REG_PSC     = 4'd5;
  localparam logic [3:0] REG_RELOAD  = 4'd6;
  localparam logic [3:0] REG_COMPARE = 4'd7;
  localparam logic [3:0] REG_CH_CTRL = 4'd8;

  // Register bit positions
  localparam int CTRL_EN_BIT     = 0;
  localparam int CTRL_ARPE_BIT   = 7;
  localparam int CH_OE_BIT       = 0;
  localparam int CH_PRELOAD_BIT  = 3;

  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic [1:0]            command;
    logic [3:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } pwmt_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  pwm_out;
    logic                  update_flag;
    logic                  irq;
  } pwmt_out_t;

endpackage

`default_nettype wire

>>> rtl/pwmt_core.sv
// Timer state, register file and per-item next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module pwmt_core import pwmt_pkg::*; #(
  parameter int COUNT_WIDTH    = 32,
  parameter int PRESCALE_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire pwmt_in_t  item,
  output pwmt_out_t      result
);

  logic                      cen_r, cen_nxt;
  logic                      arpe_r, arpe_nxt;
  logic                      uif_r, uif_nxt;
  logic                      uie_r, uie_nxt;
  logic                      oe_r, oe_nxt;
  logic                      ocpe_r, ocpe_nxt;
  logic [COUNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic [PRESCALE_WIDTH-1:0] tally_r, tally_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_wr_r, psc_wr_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_act_r, psc_act_nxt;
  logic [COUNT_WIDTH-1:0]    arr_wr_r, arr_wr_nxt;
  logic [COUNT_WIDTH-1:0]    arr_act_r, arr_act_nxt;
  logic [COUNT_WIDTH-1:0]    ccr_wr_r, ccr_wr_nxt;
  logic [COUNT_WIDTH-1:0]    ccr_act_r, ccr_act_nxt;

  logic                      do_update;
  logic [DATA_WIDTH-1:0]     rd_data;
  logic [DATA_WIDTH-1:0]     wd;

  always_comb begin
    wd          = item.write_data;
    cen_nxt     = cen_r;
    arpe_nxt    = arpe_r;
    uif_nxt     = uif_r;
    uie_nxt     = uie_r;
    oe_nxt      = oe_r;
    ocpe_nxt    = ocpe_r;
    cnt_nxt     = cnt_r;
    tally_nxt   = tally_r;
    psc_wr_nxt  = psc_wr_r;
    psc_act_nxt = psc_act_r;
    arr_wr_nxt  = arr_wr_r;
    arr_act_nxt = arr_act_r;
    ccr_wr_nxt  = ccr_wr_r;
    ccr_act_nxt = ccr_act_r;
    do_update   = 1'b0;

    if (step) begin
      case (item.command)
        CMD_TICK: begin
          if (cen_r) begin
            if (tally_r >= psc_act_r) begin
              tally_nxt = '0;
              if (cnt_r == arr_act_r) begin
                cnt_nxt   = '0;
                do_update = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end else begin
              tally_nxt = tally_r + 1'b1;
            end
          end
        end
        CMD_WRITE: begin
          case (item.reg_index)
            REG_CTRL: begin
              cen_nxt  = wd[CTRL_EN_BIT];
              arpe_nxt = wd[CTRL_ARPE_BIT];
              if (!wd[CTRL_ARPE_BIT]) arr_act_nxt = arr_wr_r;
            end
            REG_STATUS: begin
              if (!wd[0]) uif_nxt = 1'b0;
            end
            REG_EVENT: begin
              if (wd[0]) begin
                cnt_nxt   = '0;
                tally_nxt = '0;
                do_update = 1'b1;
              end
            end
            REG_IRQ_EN: uie_nxt = wd[0];
            REG_COUNT:  cnt_nxt = wd[COUNT_WIDTH-1:0];
            REG_PSC:    psc_wr_nxt = wd[PRESCALE_WIDTH-1:0];
            REG_RELOAD: begin
              arr_wr_nxt = wd[COUNT_WIDTH-1:0];
              if (!arpe_r) arr_act_nxt = wd[COUNT_WIDTH-1:0];
            end
            REG_COMPARE: begin
              ccr_wr_nxt = wd[COUNT_WIDTH-1:0];
              if (!ocpe_r) ccr_act_nxt = wd[COUNT_WIDTH-1:0];
            end
            REG_CH_CTRL: begin
              oe_nxt   = wd[CH_OE_BIT];
              ocpe_nxt = wd[CH_PRELOAD_BIT];
              if (!wd[CH_PRELOAD_BIT]) ccr_act_nxt = ccr_wr_r;
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // Update event: latch shadows, raise the sticky flag
      if (do_update) begin
        uif_nxt     = 1'b1;
        psc_act_nxt = psc_wr_r;
        if (arpe_r) arr_act_nxt = arr_wr_r;
        if (ocpe_r) ccr_act_nxt = ccr_wr_r;
      end
    end
  end

  // Read mux works on the state before the item
  always_comb begin
    rd_data = '0;
    if (item.command == CMD_READ) begin
      case (item.reg_index)
        REG_CTRL: begin
          rd_data[CTRL_EN_BIT]   = cen_r;
          rd_data[CTRL_ARPE_BIT] = arpe_r;
        end
        REG_STATUS:  rd_data[0] = uif_r;
        REG_IRQ_EN:  rd_data[0] = uie_r;
        REG_COUNT:   rd_data[COUNT_WIDTH-1:0] = cnt_r;
        REG_PSC:     rd_data[PRESCALE_WIDTH-1:0] = psc_wr_r;
        REG_RELOAD:  rd_data[COUNT_WIDTH-1:0] = arr_wr_r;
        REG_COMPARE: rd_data[COUNT_WIDTH-1:0] = ccr_wr_r;
        REG_CH_CTRL: begin
          rd_data[CH_OE_BIT]      = oe_r;
          rd_data[CH_PRELOAD_BIT] = ocpe_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.read_data   = rd_data;
    result.pwm_out     = oe_nxt && (cnt_nxt < ccr_act_nxt);
    result.update_flag = uif_nxt;
    result.irq         = uif_nxt && uie_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r     <= 1'b0;
      arpe_r    <= 1'b0;
      uif_r     <= 1'b0;
      uie_r     <= 1'b0;
      oe_r      <= 1'b0;
      ocpe_r    <= 1'b0;
      cnt_r     <= '0;
      tally_r   <= '0;
      psc_wr_r  <= '0;
      psc_act_r <= '0;
      arr_wr_r  <= '1;
      arr_act_r <= '1;
      ccr_wr_r  <= '0;
      ccr_act_r <= '0;
    end else begin
      cen_r     <= cen_nxt;
      arpe_r    <= arpe_nxt;
      uif_r     <= uif_nxt;
      uie_r     <= uie_nxt;
      oe_r      <= oe_nxt;
      ocpe_r    <= ocpe_nxt;
      cnt_r     <= cnt_nxt;
      tally_r   <= tally_nxt;
      psc_wr_r  <= psc_wr_nxt;
      psc_act_r <= psc_act_nxt;
      arr_wr_r  <= arr_wr_nxt;
      arr_act_r <= arr_act_nxt;
      ccr_wr_r  <= ccr_wr_nxt;
      ccr_act_r <= ccr_act_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pwm_timer_with_update_flag.sv
// Top level of the up-counting PWM timer with a sticky update flag.
// Each item passes the input register, then the result register, on its way
// to the result transfer; throughput: one item per cycle while the sink keeps
// out_ready high, set by the single pass through pwmt_core.
// Reset (rst_n low, synchronous): both pipeline stages empty, all timer
// state cleared, reload registers set to all ones.
`timescale 1ns / 1ps
`default_nettype none

module pwm_timer_with_update_flag import pwmt_pkg::*; #(
  parameter int COUNT_WIDTH    = 32,
  parameter int PRESCALE_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire pwmt_in_t  in_payload,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output pwmt_out_t      out_payload
);

  // Input stage: hold one accepted item until the core consumes it
  logic      in_valid_r, in_valid_nxt;
  pwmt_in_t  in_item_r;

  // Result stage: hold one result until the sink takes it
  logic      out_valid_r, out_valid_nxt;
  pwmt_out_t out_item_r;

  logic      advance;
  logic      step;
  pwmt_out_t core_result;

  // Advance whenever the result slot is free or being emptied this cycle
  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_ready) in_valid_nxt = in_valid;
    if (advance)  out_valid_nxt = in_valid_r;
  end

  pwmt_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_payload;
    if (step) out_item_r <= core_result;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

endmodule

`default_nettype wire

>>> bench/tb_pwm_timer_with_update_flag.sv
// Self-checking testbench for the PWM timer with sticky update flag.
`timescale 1ns / 1ps

module tb_pwm_timer_with_update_flag;
  import pwmt_pkg::*;

  localparam int COUNT_W      = 32;
  localparam int PSC_W        = 16;
  localparam int ITEMS_TOTAL  = 1200;
  localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int HOLD_AFTER   = 300;   // results seen before the hold-off
  localparam int DRAIN_CYCLES = 8;     // slack for results still in the block

  // Command 3 is not decoded by the block; indexes 9 to 15 are unmapped.
  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [3:0] REG_UNMAPPED = 4'd15;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pwmt_in_t  in_payload = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pwmt_out_t out_payload;

  pwm_timer_with_update_flag #(
    .COUNT_WIDTH    (COUNT_W),
    .PRESCALE_WIDTH (PSC_W)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  always #2 clk = ~clk;

  // Bus accesses waiting to be driven, and the results they should give.
  pwmt_in_t  pending_accesses[$];
  pwmt_out_t expected_results[$];
  pwmt_out_t oldest_result;

  int  total_accesses  = 0;
  int  accesses_taken  = 0;
  int  results_seen    = 0;
  int  mismatches      = 0;
  int  send_gap        = 0;
  int  recv_stall      = 0;
  bit  send_quiet      = 1'b0;
  bit  recv_quiet      = 1'b0;
  bit  hold_off        = 1'b0;
  logic in_took        = 1'b0;
  logic out_took       = 1'b0;

  // Timer state as the predictor sees it.
  logic               run_enable, arpe_on, flag_set, irq_on;
  logic               ch_enable, ccr_preload_on;
  logic [COUNT_W-1:0] cnt, arr_shadow, arr_live, ccr_shadow, ccr_live;
  logic [PSC_W-1:0]   psc_tally, psc_shadow, psc_live;

  initial begin
    run_enable     = 1'b0;
    arpe_on        = 1'b0;
    flag_set       = 1'b0;
    irq_on         = 1'b0;
    ch_enable      = 1'b0;
    ccr_preload_on = 1'b0;
    cnt            = '0;
    psc_tally      = '0;
    psc_shadow     = '0;
    psc_live       = '0;
    arr_shadow     = '1;
    arr_live       = '1;
    ccr_shadow     = '0;
    ccr_live       = '0;
  end

  // Update event: raise the flag and move the shadow values across.
  function automatic void load_shadows();
    flag_set = 1'b1;
    psc_live = psc_shadow;
    if (arpe_on) arr_live = arr_shadow;
    if (ccr_preload_on) ccr_live = ccr_shadow;
  endfunction

  // Apply one bus access to the predicted timer and return its result.
  function automatic pwmt_out_t timer_model_step(pwmt_in_t acc);
    pwmt_out_t res;
    logic [31:0] wd;
    res = '0;
    wd  = acc.write_data;
    case (acc.command)
      CMD_TICK: begin
        if (run_enable) begin
          if (psc_tally >= psc_live) begin
            psc_tally = '0;
            if (cnt == arr_live) begin
              cnt = '0;
              load_shadows();
            end else begin
              cnt = cnt + 1'b1;
            end
          end else begin
            psc_tally = psc_tally + 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        case (acc.reg_index)
          REG_CTRL: begin
            run_enable = wd[CTRL_EN_BIT];
            arpe_on    = wd[CTRL_ARPE_BIT];
            if (!arpe_on) arr_live = arr_shadow;
          end
          REG_STATUS: if (!wd[0]) flag_set = 1'b0;
          REG_EVENT: begin
            if (wd[0]) begin
              cnt       = '0;
              psc_tally = '0;
              load_shadows();
            end
          end
          REG_IRQ_EN: irq_on = wd[0];
          REG_COUNT:  cnt = wd[COUNT_W-1:0];
          REG_PSC:    psc_shadow = wd[PSC_W-1:0];
          REG_RELOAD: begin
            arr_shadow = wd[COUNT_W-1:0];
            if (!arpe_on) arr_live = arr_shadow;
          end
          REG_COMPARE: begin
            ccr_shadow = wd[COUNT_W-1:0];
            if (!ccr_preload_on) ccr_live = ccr_shadow;
          end
          REG_CH_CTRL: begin
            ch_enable      = wd[CH_OE_BIT];
            ccr_preload_on = wd[CH_PRELOAD_BIT];
            if (!ccr_preload_on) ccr_live = ccr_shadow;
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        case (acc.reg_index)
          REG_CTRL: begin
            res.read_data[CTRL_EN_BIT]   = run_enable;
            res.read_data[CTRL_ARPE_BIT] = arpe_on;
          end
          REG_STATUS:  res.read_data[0] = flag_set;
          REG_IRQ_EN:  res.read_data[0] = irq_on;
          REG_COUNT:   res.read_data = 32'(cnt);
          REG_PSC:     res.read_data = 32'(psc_shadow);
          REG_RELOAD:  res.read_data = 32'(arr_shadow);
          REG_COMPARE: res.read_data = 32'(ccr_shadow);
          REG_CH_CTRL: begin
            res.read_data[CH_OE_BIT]      = ch_enable;
            res.read_data[CH_PRELOAD_BIT] = ccr_preload_on;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.pwm_out     = ch_enable && (cnt < ccr_live);
    res.update_flag = flag_set;
    res.irq         = flag_set && irq_on;
    return res;
  endfunction

  task automatic queue_access(input logic [1:0] cmd, input logic [3:0] idx,
                              input logic [31:0] data);
    pwmt_in_t acc;
    acc.command    = cmd;
    acc.reg_index  = idx;
    acc.write_data = data;
    pending_accesses.push_back(acc);
  endtask

  // Keep the bits under the mask, fill the rest with noise the block ignores.
  function automatic logic [31:0] with_noise(input logic [31:0] value,
                                             input logic [31:0] keep);
    return ($urandom & ~keep) | (value & keep);
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Monitor: sample both channels at the rising edge. Check results before
  // predicting, so that a stray result never meets this cycle's expectation.
  always @(posedge clk) begin
    in_took  <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_data %h with nothing outstanding",
               out_payload.read_data);
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_payload.read_data !== oldest_result.read_data) begin
          $error("read_data: expected %h, got %h",
                 oldest_result.read_data, out_payload.read_data);
          mismatches++;
        end
        if (out_payload.pwm_out !== oldest_result.pwm_out) begin
          $error("pwm_out: expected %b, got %b",
                 oldest_result.pwm_out, out_payload.pwm_out);
          mismatches++;
        end
        if (out_payload.update_flag !== oldest_result.update_flag) begin
          $error("update_flag: expected %b, got %b",
                 oldest_result.update_flag, out_payload.update_flag);
          mismatches++;
        end
        if (out_payload.irq !== oldest_result.irq) begin
          $error("irq: expected %b, got %b",
                 oldest_result.irq, out_payload.irq);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(timer_model_step(in_payload));
      accesses_taken <= accesses_taken + 1;
    end
  end

  // Driver: change inputs at the falling edge. Hold an offered transfer
  // until it is taken, then wait out a random gap before the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else begin
      if (in_took) begin
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        send_gap = draw_wait(send_quiet);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        in_payload <= pending_accesses.pop_front();
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall a random number of cycles per result, with quiet
  // stretches, and drop ready entirely while the long hold-off runs.
  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      recv_stall = draw_wait(recv_quiet);
    end
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long hold-off: the sender keeps offering, so the block fills and
  // must stall its input.
  initial begin
    wait (results_seen >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: end the run if no transfer happens for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("[pwm_timer_with_update_flag] ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          seq_len;
    int          pick;
    logic [31:0] v;

    rst_n = 1'b0;

    // Directed: reset values, ignored commands and registers, width masks,
    // a wrap with update, flag clear rules, counting above reload, preload
    // switching and a wrap at the top of the full count range.
    queue_access(CMD_READ, REG_RELOAD, '0);
    queue_access(CMD_READ, REG_EVENT, '0);
    queue_access(CMD_UNUSED, REG_CTRL, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_PSC, 32'hFFFF_FFFF);
    queue_access(CMD_READ, REG_PSC, '0);
    queue_access(CMD_WRITE, REG_PSC, 32'h0);
    queue_access(CMD_WRITE, REG_RELOAD, 32'd2);
    queue_access(CMD_WRITE, REG_COMPARE, 32'd1);
    queue_access(CMD_WRITE, REG_CH_CTRL, 32'hFFFF_FFF1);
    queue_access(CMD_WRITE, REG_IRQ_EN, 32'h1);
    queue_access(CMD_WRITE, REG_CTRL, 32'hFFFF_FF7F);
    repeat (4) queue_access(CMD_TICK, '0, '0);
    queue_access(CMD_WRITE, REG_STATUS, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_STATUS, 32'hFFFF_FFFE);
    queue_access(CMD_WRITE, REG_COUNT, 32'hFFFF_FFFF);
    queue_access(CMD_TICK, '0, '0);
    queue_access(CMD_WRITE, REG_CH_CTRL, 32'h9);
    queue_access(CMD_WRITE, REG_COMPARE, 32'd3);
    queue_access(CMD_WRITE, REG_CH_CTRL, 32'h1);
    queue_access(CMD_WRITE, REG_CTRL, 32'h81);
    queue_access(CMD_WRITE, REG_RELOAD, 32'hFFFF_FFFF);
    queue_access(CMD_WRITE, REG_EVENT, 32'h1);
    queue_access(CMD_WRITE, REG_COUNT, 32'hFFFF_FFFF);
    queue_access(CMD_TICK, '0, '0);

    // Random: mostly a set-up burst followed by a run of ticks with reads
    // and odd writes mixed in; now and then pure noise.
    while (pending_accesses.size() < ITEMS_TOTAL) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_access(CMD_WRITE, REG_PSC, with_noise($urandom_range(0, 3), 32'h0000_FFFF));
        if ($urandom_range(0, 9) == 0)
          queue_access(CMD_WRITE, REG_RELOAD, 32'hFFFF_FFFF - $urandom_range(0, 8));
        else
          queue_access(CMD_WRITE, REG_RELOAD, $urandom_range(0, 24));
        queue_access(CMD_WRITE, REG_COMPARE, $urandom_range(0, 26));
        queue_access(CMD_WRITE, REG_CH_CTRL, $urandom);
        queue_access(CMD_WRITE, REG_IRQ_EN, $urandom);
        v = $urandom;
        if ($urandom_range(0, 9) != 0) v[CTRL_EN_BIT] = 1'b1;
        queue_access(CMD_WRITE, REG_CTRL, v);
        v = $urandom;
        if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
        queue_access(CMD_WRITE, REG_EVENT, v);
        // Occasionally start just below the top of the count range.
        if ($urandom_range(0, 7) == 0)
          queue_access(CMD_WRITE, REG_COUNT, 32'hFFFF_FFFF - $urandom_range(0, 20));
        queue_access(CMD_WRITE, REG_STATUS, $urandom);
        seq_len = $urandom_range(8, 60);
        repeat (seq_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 72) begin
            queue_access(CMD_TICK, 4'($urandom), $urandom);
          end else if (pick < 84) begin
            queue_access(CMD_READ, 4'($urandom), $urandom);
          end else if (pick < 96) begin
            case ($urandom_range(0, 5))
              0: queue_access(CMD_WRITE, REG_STATUS, $urandom);
              1: queue_access(CMD_WRITE, REG_COMPARE, $urandom_range(0, 26));
              2: queue_access(CMD_WRITE, REG_RELOAD, $urandom_range(0, 24));
              3: queue_access(CMD_WRITE, REG_EVENT, $urandom);
              4: queue_access(CMD_WRITE, REG_CH_CTRL, $urandom);
              default: queue_access(CMD_WRITE, REG_PSC,
                                    with_noise($urandom_range(0, 3), 32'h0000_FFFF));
            endcase
          end else begin
            queue_access(CMD_UNUSED, 4'($urandom), $urandom);
          end
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_access(2'($urandom), 4'($urandom), $urandom);
      end
    end
    total_accesses = pending_accesses.size();

    // Release reset on a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every access taken and every result seen, then let the
    // pipeline settle so that a stray result would still show up.
    while (accesses_taken < total_accesses || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("[pwm_timer_with_update_flag] OK");
    else
      $display("[pwm_timer_with_update_flag] ERROR");
    $finish;
  end

endmodule
